### src/twd_pkg.sv
// ----------------------------------------------------------------------------
// twd_pkg
// Shared types and constants of the tile window decomposer: request and
// result payloads, crop margin group, status codes and register indexes.
// ----------------------------------------------------------------------------
package twd_pkg;

  localparam int unsigned IN_W      = 32;
  localparam int unsigned OUT_IDX_W = 32;
  localparam int unsigned TSIZE_W   = 13;
  localparam int unsigned CROP_W    = 12;
  localparam int unsigned LIM_W     = 4;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned DIV_BPS   = 4;

  localparam logic [TSIZE_W-1:0] TILE_MAX  = 13'd4096;
  localparam logic [TSIZE_W-1:0] TILE_RST  = 13'd256;

  localparam logic [CFG_IDX_W-1:0] REG_TILE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TILE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_TILES_X = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_TILES_Y = 2'd3;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_TOO_MANY = 2'd2
  } status_e;

  typedef struct packed {
    logic signed [IN_W-1:0] win_xmin;
    logic signed [IN_W-1:0] win_ymin;
    logic signed [IN_W-1:0] win_xmax;
    logic signed [IN_W-1:0] win_ymax;
  } twd_req_t;

  typedef struct packed {
    logic [CROP_W-1:0] left;
    logic [CROP_W-1:0] top;
    logic [CROP_W-1:0] right;
    logic [CROP_W-1:0] bottom;
  } twd_crop_t;

  typedef struct packed {
    status_e                     status;
    logic signed [OUT_IDX_W-1:0] tile_col;
    logic signed [OUT_IDX_W-1:0] tile_row;
    logic [CROP_W-1:0]           crop_left;
    logic [CROP_W-1:0]           crop_top;
    logic [CROP_W-1:0]           crop_right;
    logic [CROP_W-1:0]           crop_bottom;
    logic                        last;
  } twd_res_t;

endpackage

### src/twd_div_lane.sv
// ----------------------------------------------------------------------------
// twd_div_lane
// Pipelined restoring divider: unsigned dividend by a 13-bit tile size,
// DIV_BPS quotient bits per stage, all stages advance together on adv_i.
// ----------------------------------------------------------------------------
module twd_div_lane #(
  parameter int unsigned CW = 32
) (
  input  logic                         clk_i,
  input  logic                         adv_i,
  input  logic [CW-1:0]                dvd_i,
  input  logic [twd_pkg::TSIZE_W-1:0]  dvs_i,
  output logic [CW-1:0]                quo_o,
  output logic [twd_pkg::CROP_W-1:0]   rem_o
);
  import twd_pkg::*;

  localparam int unsigned NS = (CW + DIV_BPS - 1) / DIV_BPS;
  localparam int unsigned DW = NS * DIV_BPS;
  localparam int unsigned RW = CROP_W;

  logic [DW-1:0] dvd_in [NS];
  logic [DW-1:0] quo_in [NS];
  logic [RW-1:0] rem_in [NS];
  logic [DW-1:0] dvd_d  [NS];
  logic [DW-1:0] quo_d  [NS];
  logic [RW-1:0] rem_d  [NS];
  logic [DW-1:0] dvd_q  [NS];
  logic [DW-1:0] quo_q  [NS];
  logic [RW-1:0] rem_q  [NS];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    if (k == 0) begin : g_first
      assign dvd_in[k] = DW'(dvd_i);
      assign quo_in[k] = '0;
      assign rem_in[k] = '0;
    end else begin : g_next
      assign dvd_in[k] = dvd_q[k-1];
      assign quo_in[k] = quo_q[k-1];
      assign rem_in[k] = rem_q[k-1];
    end

    always_comb begin : p_step
      logic [DW-1:0] dd;
      logic [DW-1:0] qq;
      logic [RW-1:0] rr;
      logic [RW:0]   t;
      logic [RW:0]   s;
      dd = dvd_in[k];
      qq = quo_in[k];
      rr = rem_in[k];
      for (int b = 0; b < DIV_BPS; b++) begin
        // bring down the next dividend bit, msb first
        t  = {rr, dd[DW-1]};
        dd = dd << 1;
        s  = t - dvs_i;
        if (t >= dvs_i) begin
          rr = s[RW-1:0];
          qq = {qq[DW-2:0], 1'b1};
        end else begin
          rr = t[RW-1:0];
          qq = {qq[DW-2:0], 1'b0};
        end
      end
      dvd_d[k] = dd;
      quo_d[k] = qq;
      rem_d[k] = rr;
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        dvd_q[k] <= dvd_d[k];
        quo_q[k] <= quo_d[k];
        rem_q[k] <= rem_d[k];
      end
    end
  end

  assign quo_o = quo_q[NS-1][CW-1:0];
  assign rem_o = rem_q[NS-1];

endmodule

### src/twd_emit.sv
// ----------------------------------------------------------------------------
// twd_emit
// Tile walker: takes one classified window and sends its results row by
// row through the output register, one per clock.
// ----------------------------------------------------------------------------
module twd_emit #(
  parameter int unsigned QW = 33,
  parameter int unsigned IW = 3
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     ld_i,
  input  twd_pkg::status_e         st_i,
  input  logic signed [QW-1:0]     col0_i,
  input  logic signed [QW-1:0]     row0_i,
  input  logic [IW-1:0]            xl_i,
  input  logic [IW-1:0]            yl_i,
  input  twd_pkg::twd_crop_t       crop_i,
  output logic                     take_o,
  output logic                     res_valid_o,
  output twd_pkg::twd_res_t        res_o
);
  import twd_pkg::*;

  localparam int unsigned SW = (QW > OUT_IDX_W) ? QW : OUT_IDX_W;

  logic                 act_d, act_q;
  logic [IW-1:0]        x_d, x_q;
  logic [IW-1:0]        y_d, y_q;
  status_e              st_q;
  logic signed [QW-1:0] col0_q, row0_q;
  logic [IW-1:0]        xl_q, yl_q;
  twd_crop_t            crop_q;
  logic                 res_v_q;
  twd_res_t             res_d, res_q;
  logic                 last_now;
  logic [SW-1:0]        col_w, row_w;

  assign last_now = (x_q == xl_q) && (y_q == yl_q);
  assign take_o   = !act_q || last_now;

  assign col_w = SW'(col0_q) + SW'(x_q);
  assign row_w = SW'(row0_q) + SW'(y_q);

  always_comb begin
    res_d.status      = st_q;
    res_d.tile_col    = col_w[OUT_IDX_W-1:0];
    res_d.tile_row    = row_w[OUT_IDX_W-1:0];
    res_d.crop_left   = (x_q == '0)   ? crop_q.left   : '0;
    res_d.crop_top    = (y_q == '0)   ? crop_q.top    : '0;
    res_d.crop_right  = (x_q == xl_q) ? crop_q.right  : '0;
    res_d.crop_bottom = (y_q == yl_q) ? crop_q.bottom : '0;
    res_d.last        = last_now;
  end

  always_comb begin
    act_d = act_q;
    x_d   = x_q;
    y_d   = y_q;
    if (act_q && !last_now) begin
      if (x_q == xl_q) begin
        x_d = '0;
        y_d = y_q + 1'b1;
      end else begin
        x_d = x_q + 1'b1;
      end
    end else begin
      act_d = ld_i;
      x_d   = '0;
      y_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q   <= 1'b0;
      x_q     <= '0;
      y_q     <= '0;
      res_v_q <= 1'b0;
    end else begin
      act_q   <= act_d;
      x_q     <= x_d;
      y_q     <= y_d;
      res_v_q <= act_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_i) begin
      st_q   <= st_i;
      col0_q <= col0_i;
      row0_q <= row0_i;
      xl_q   <= xl_i;
      yl_q   <= yl_i;
      crop_q <= crop_i;
    end
    if (act_q) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o = res_v_q;
  assign res_o       = res_q;

  a_err_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.status != ST_OK |-> res_o.last)
    else $error("error result without last");

  a_ld_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ld_i |-> take_o)
    else $error("window loaded while walker busy");

  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    act_q |-> (x_q <= xl_q && y_q <= yl_q))
    else $error("tile walk past last tile");

  a_ld_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ld_i |=> act_q && x_q == '0 && y_q == '0)
    else $error("walk did not restart at first tile");

endmodule

### src/tile_window_decomposer_unit.sv
// ----------------------------------------------------------------------------
// tile_window_decomposer_unit
// A window request is taken at a clock edge with start high and busy low.
// It passes a prep stage, ceil(COORD_WIDTH/4) divider stages (four lanes in
// parallel, 4 quotient bits each) and a classify stage, and then the tile
// walker. A window then sends one result per clock: one per tile, row by
// row, or a single error result. Results are never held off:
// res_valid_o is high for exactly one cycle per result. New windows flow
// into the divider while earlier ones are still sent; busy is high only
// while the classify stage holds a window that the tile walker cannot take
// yet, so the walker and its tile count set the sustained rate.
// Configuration writes take effect at once and belong to idle periods.
// ----------------------------------------------------------------------------
module tile_window_decomposer_unit #(
  parameter int unsigned MAX_TILES_PER_AXIS = 8,
  parameter int unsigned COORD_WIDTH        = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  twd_pkg::twd_req_t             in_i,
  input  logic                          cfg_we_i,
  input  logic [twd_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [twd_pkg::TSIZE_W-1:0]   cfg_wdata_i,
  output logic                          res_valid_o,
  output twd_pkg::twd_res_t             res_o
);
  import twd_pkg::*;

  localparam int unsigned CW  = COORD_WIDTH;
  localparam int unsigned QW  = CW + 1;
  localparam int unsigned DFW = CW + 2;
  localparam int unsigned NS  = (CW + DIV_BPS - 1) / DIV_BPS;
  localparam int unsigned IW  = (MAX_TILES_PER_AXIS > 1) ? $clog2(MAX_TILES_PER_AXIS) : 1;
  localparam logic [LIM_W-1:0] LIM_CAP = LIM_W'(MAX_TILES_PER_AXIS + 1);

  // configuration, stored already clamped
  logic [TSIZE_W-1:0] tw_q, th_q;
  logic [LIM_W-1:0]   limx_q, limy_q;

  function automatic logic [TSIZE_W-1:0] clamp_size(input logic [TSIZE_W-1:0] v);
    if (v == '0) begin
      return TSIZE_W'(1);
    end
    if (v > TILE_MAX) begin
      return TILE_MAX;
    end
    return v;
  endfunction

  function automatic logic [LIM_W-1:0] clamp_lim(input logic [LIM_W-1:0] v);
    return (v > LIM_CAP) ? LIM_CAP : v;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tw_q   <= TILE_RST;
      th_q   <= TILE_RST;
      limx_q <= LIM_CAP;
      limy_q <= LIM_CAP;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_TILE_WIDTH:  tw_q   <= clamp_size(cfg_wdata_i);
        REG_TILE_HEIGHT: th_q   <= clamp_size(cfg_wdata_i);
        REG_MAX_TILES_X: limx_q <= clamp_lim(cfg_wdata_i[LIM_W-1:0]);
        REG_MAX_TILES_Y: limy_q <= clamp_lim(cfg_wdata_i[LIM_W-1:0]);
        default: ;
      endcase
    end
  end

  // pipeline control
  logic adv, take, ld, acc;
  logic pre_v_q;
  logic [NS-1:0] div_v_q;
  logic post_v_q;

  assign adv  = !post_v_q || take;
  assign ld   = post_v_q && take;
  assign busy = !adv;
  assign acc  = start && adv;

  // prep: fold negative values so the divider sees magnitudes only
  function automatic logic [CW:0] prep_min(input logic [CW-1:0] c);
    return {c[CW-1], (c[CW-1] ? ~c : c)};
  endfunction

  function automatic logic [CW:0] prep_max(input logic [CW-1:0] c);
    logic [CW:0] e;
    e = {c[CW-1], c} - {{CW{1'b0}}, 1'b1};
    return {e[CW], (e[CW] ? ~e[CW-1:0] : e[CW-1:0])};
  endfunction

  logic [CW:0]   pr [4];
  logic [CW-1:0] mag_q [4];
  logic [3:0]    sg_pre_q;
  logic [3:0]    div_sg_q [NS];

  assign pr[0] = prep_min(CW'($unsigned(in_i.win_xmin)));
  assign pr[1] = prep_min(CW'($unsigned(in_i.win_ymin)));
  assign pr[2] = prep_max(CW'($unsigned(in_i.win_xmax)));
  assign pr[3] = prep_max(CW'($unsigned(in_i.win_ymax)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_v_q  <= 1'b0;
      div_v_q  <= '0;
      post_v_q <= 1'b0;
    end else if (adv) begin
      pre_v_q  <= acc;
      div_v_q  <= {div_v_q[NS-2:0], pre_v_q};
      post_v_q <= div_v_q[NS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 4; i++) begin
        mag_q[i]    <= pr[i][CW-1:0];
        sg_pre_q[i] <= pr[i][CW];
      end
      div_sg_q[0] <= sg_pre_q;
      for (int k = 1; k < NS; k++) begin
        div_sg_q[k] <= div_sg_q[k-1];
      end
    end
  end

  // divider lanes: xmin, ymin, xmax-1, ymax-1
  logic [CW-1:0]     quo [4];
  logic [CROP_W-1:0] rem [4];

  for (genvar g = 0; g < 4; g++) begin : g_lane
    twd_div_lane #(
      .CW (CW)
    ) u_lane (
      .clk_i (clk_i),
      .adv_i (adv),
      .dvd_i (mag_q[g]),
      .dvs_i ((g % 2 == 1) ? th_q : tw_q),
      .quo_o (quo[g]),
      .rem_o (rem[g])
    );
  end

  // classify
  logic [3:0]            sgl;
  logic signed [QW-1:0]  qs [4];
  logic [CROP_W-1:0]     twm1, thm1;
  logic signed [DFW-1:0] diff_x, diff_y;
  status_e               st_x, st_y, st;
  logic                  ok;
  twd_crop_t             crop_c;

  function automatic status_e axis_status(input logic signed [DFW-1:0] diff,
                                          input logic [LIM_W-1:0] lim);
    if (diff[DFW-1]) begin
      return (diff == '1 && lim != '0) ? ST_EMPTY : ST_TOO_MANY;
    end
    if (lim == '0 || diff >= DFW'(lim - 1'b1)) begin
      return ST_TOO_MANY;
    end
    return ST_OK;
  endfunction

  assign sgl = div_sg_q[NS-1];

  for (genvar g = 0; g < 4; g++) begin : g_fix
    // negative input: floor quotient is minus one minus the folded quotient
    assign qs[g] = sgl[g] ? ~{1'b0, quo[g]} : {1'b0, quo[g]};
  end

  assign twm1 = CROP_W'(tw_q - 1'b1);
  assign thm1 = CROP_W'(th_q - 1'b1);

  assign crop_c.left   = sgl[0] ? (twm1 - rem[0]) : rem[0];
  assign crop_c.top    = sgl[1] ? (thm1 - rem[1]) : rem[1];
  assign crop_c.right  = sgl[2] ? rem[2] : (twm1 - rem[2]);
  assign crop_c.bottom = sgl[3] ? rem[3] : (thm1 - rem[3]);

  assign diff_x = DFW'(qs[2]) - DFW'(qs[0]);
  assign diff_y = DFW'(qs[3]) - DFW'(qs[1]);
  assign st_x   = axis_status(diff_x, limx_q);
  assign st_y   = axis_status(diff_y, limy_q);
  assign st     = (st_x != ST_OK) ? st_x : st_y;
  assign ok     = (st == ST_OK);

  status_e              p_st_q;
  logic signed [QW-1:0] p_col0_q, p_row0_q;
  logic [IW-1:0]        p_xl_q, p_yl_q;
  twd_crop_t            p_crop_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p_st_q   <= st;
      p_col0_q <= ok ? qs[0] : '0;
      p_row0_q <= ok ? qs[1] : '0;
      p_xl_q   <= ok ? diff_x[IW-1:0] : '0;
      p_yl_q   <= ok ? diff_y[IW-1:0] : '0;
      p_crop_q <= ok ? crop_c : '0;
    end
  end

  twd_emit #(
    .QW (QW),
    .IW (IW)
  ) u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ld_i        (ld),
    .st_i        (p_st_q),
    .col0_i      (p_col0_q),
    .row0_i      (p_row0_q),
    .xl_i        (p_xl_q),
    .yl_i        (p_yl_q),
    .crop_i      (p_crop_q),
    .take_o      (take),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> post_v_q && $stable(p_st_q) && $stable(p_col0_q) && $stable(p_row0_q))
    else $error("classified window changed during stall");

endmodule
